// ----- rtl/core/fvn_pkg.sv -----
// Shared constants and types for the fractal value noise block.
`timescale 1ns / 1ps
`default_nettype none

package fvn_pkg;

  // Hash mixing primes
  localparam logic [31:0] HP2 = 32'd2246822519;
  localparam logic [31:0] HP3 = 32'd3266489917;
  localparam logic [31:0] HP5 = 32'd374761393;
  localparam int unsigned SH_A = 13;
  localparam int unsigned SH_B = 16;

  // Fraction bits of the inverse scale register
  localparam int unsigned SCALE_FRAC = 16;
  // Largest supported fraction width of the octave coordinate
  localparam int unsigned FRAC_MAX = 24;

  localparam logic [16:0] ROUGH_ONE = 17'h10000;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED  = 2'd0,
    REG_ROUGH = 2'd1,
    REG_INV   = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/core/fvn_hash.sv -----
// Three-stage pipelined seeded 2D hash of one lattice point.
`timescale 1ns / 1ps
`default_nettype none

module fvn_hash (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] seed,
  input  logic [31:0] u,
  input  logic [31:0] v,
  output logic [31:0] hash
);
  import fvn_pkg::*;

  logic [31:0] add_r, mul_r, p_r, q_r;
  logic [31:0] pre, pmix;

  assign pre  = add_r + mul_r;
  assign pmix = p_r ^ (p_r >> SH_A);

  always_ff @(posedge clk) begin
    if (en) begin
      add_r <= seed + u + HP5;
      mul_r <= v * HP3;
      p_r   <= pre * HP2;
      q_r   <= pmix * HP3;
    end
  end

  assign hash = q_r ^ (q_r >> SH_B);

endmodule

`default_nettype wire

// ----- rtl/core/fractal_value_noise_2d.sv -----
// Top level: six-octave fractal value noise and cell hash, fully pipelined.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_x, in_y          | request in
//  out     | out_valid, out_stall, out_noise_value,  | request out
//          | out_cell_hash                           |
//  cfg     | cfg_we, cfg_index, cfg_wdata            | write only
//
// One request enters per cycle unless the pipeline is stalled. The stages are
// the scale multiply, three hash stages, four blend stages, two stages per
// octave nesting step, and the output register.
// Reset (rst_n low, synchronous) clears all valid bits and loads the default
// seed, roughness and inverse scale. A stalled result in the output register
// freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module fractal_value_noise_2d #(
  parameter int OCTAVES       = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_noise_value,
  output logic [31:0]                   out_cell_hash,
  input  logic                          cfg_we,
  input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import fvn_pkg::*;

  localparam int FW  = FRACTION_BITS;
  localparam int PW  = 33 + FW;          // lerp product width
  localparam int LAT = 2 * OCTAVES + 7;  // pipeline depth
  localparam logic [FW:0] FONE = {1'b1, {FW{1'b0}}};

  // ---------------- configuration ----------------
  logic [31:0] seed_r;
  logic [16:0] rough_r;                  // already saturated to 1.0
  logic [23:0] inv_r;
  logic [16:0] wa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      rough_r <= 17'd32768;
      inv_r   <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:  seed_r <= cfg_wdata;
        REG_ROUGH: rough_r <= (cfg_wdata[16:0] > ROUGH_ONE) ? ROUGH_ONE : cfg_wdata[16:0];
        REG_INV:   inv_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign wa = ROUGH_ONE - rough_r;

  // ---------------- flow control ----------------
  logic           en;
  logic [LAT-1:0] v_r;

  assign en        = !v_r[LAT-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // ---------------- stage 1: scale ----------------
  logic signed [56:0] pxm, pym;
  logic        [63:0] px_r, py_r;
  logic        [31:0] x_r, y_r;

  assign pxm = 57'(in_x) * $signed(57'(inv_r));
  assign pym = 57'(in_y) * $signed(57'(inv_r));

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= {{7{pxm[56]}}, pxm};
      py_r <= {{7{pym[56]}}, pym};
      x_r  <= in_x;
      y_r  <= in_y;
    end
  end

  // Coordinates padded below so the fraction select never runs off bit 0
  logic [63+FRAC_MAX:0] pxw, pyw;
  assign pxw = {px_r, {FRAC_MAX{1'b0}}};
  assign pyw = {py_r, {FRAC_MAX{1'b0}}};

  // ---------------- cell hash ----------------
  logic [31:0] cell_h;
  logic [31:0] chl_r [3];                // blend stages 5..7
  logic [31:0] chs_r [OCTAVES];          // nest sum stages
  logic [31:0] chm_r [OCTAVES];          // nest multiply stages

  fvn_hash u_cell (
    .clk(clk), .en(en), .seed(seed_r), .u(x_r), .v(y_r), .hash(cell_h)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      chl_r[0] <= cell_h;
      chl_r[1] <= chl_r[0];
      chl_r[2] <= chl_r[1];
      chs_r[0] <= chl_r[2];
    end
  end

  // ---------------- octave lattices ----------------
  logic [31:0]   hq    [OCTAVES][4];
  logic [FW-1:0] fxd_r [OCTAVES][3];
  logic [FW-1:0] fyd_r [OCTAVES][5];
  logic [PW-1:0] l1a_r [OCTAVES][2];
  logic [PW-1:0] l1b_r [OCTAVES][2];
  logic [31:0]   l2_r  [OCTAVES][2];
  logic [PW-1:0] l3a_r [OCTAVES];
  logic [PW-1:0] l3b_r [OCTAVES];
  logic [31:0]   ncs_r [OCTAVES][OCTAVES]; // slot 0: running sum
  logic [31:0]   ncm_r [OCTAVES][OCTAVES];

  for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
    localparam int FOFF = SCALE_FRAC + FRAC_MAX + k - FW;
    logic [31:0]   ix, iy;
    logic [FW-1:0] fx, fy;
    logic [PW-1:0] s0, s1, s2;

    assign ix = px_r[SCALE_FRAC + k +: 32];
    assign iy = py_r[SCALE_FRAC + k +: 32];
    assign fx = pxw[FOFF +: FW];
    assign fy = pyw[FOFF +: FW];

    for (genvar c = 0; c < 4; c++) begin : g_corner
      fvn_hash u_hash (
        .clk (clk),
        .en  (en),
        .seed(seed_r),
        .u   (ix + 32'(c % 2)),
        .v   (iy + 32'(c / 2)),
        .hash(hq[k][c])
      );
    end

    assign s0 = l1a_r[k][0] + l1b_r[k][0];
    assign s1 = l1a_r[k][1] + l1b_r[k][1];
    assign s2 = l3a_r[k] + l3b_r[k];

    always_ff @(posedge clk) begin
      if (en) begin
        fxd_r[k][0] <= fx;
        fxd_r[k][1] <= fxd_r[k][0];
        fxd_r[k][2] <= fxd_r[k][1];
        fyd_r[k][0] <= fy;
        for (int i = 1; i < 5; i++) fyd_r[k][i] <= fyd_r[k][i-1];
        // x blend on both rows
        l1a_r[k][0] <= PW'(hq[k][0]) * PW'(FONE - {1'b0, fxd_r[k][2]});
        l1b_r[k][0] <= PW'(hq[k][1]) * PW'(fxd_r[k][2]);
        l1a_r[k][1] <= PW'(hq[k][2]) * PW'(FONE - {1'b0, fxd_r[k][2]});
        l1b_r[k][1] <= PW'(hq[k][3]) * PW'(fxd_r[k][2]);
        l2_r[k][0]  <= s0[FW +: 32];
        l2_r[k][1]  <= s1[FW +: 32];
        // y blend between rows
        l3a_r[k]    <= PW'(l2_r[k][0]) * PW'(FONE - {1'b0, fyd_r[k][4]});
        l3b_r[k]    <= PW'(l2_r[k][1]) * PW'(fyd_r[k][4]);
        ncs_r[0][k] <= s2[FW +: 32];
      end
    end
  end

  // ---------------- octave nesting ----------------
  logic [48:0] ma_r [OCTAVES];
  logic [48:0] mb_r [OCTAVES];

  for (genvar j = 1; j < OCTAVES; j++) begin : g_nest
    logic [49:0] sum;
    assign sum = {1'b0, ma_r[j]} + {1'b0, mb_r[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        ma_r[j]  <= 49'(wa) * 49'(ncs_r[j-1][j]);
        mb_r[j]  <= 49'(rough_r) * 49'(ncs_r[j-1][0]);
        ncm_r[j] <= ncs_r[j-1];
        chm_r[j] <= chs_r[j-1];
        for (int k = 1; k < OCTAVES; k++) ncs_r[j][k] <= ncm_r[j][k];
        ncs_r[j][0] <= (sum[49:48] != 2'b00) ? 32'hFFFF_FFFF : sum[47:16];
        chs_r[j]    <= chm_r[j];
      end
    end
  end

  // ---------------- output register ----------------
  logic [31:0] out_noise_r, out_hash_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_noise_r <= ncs_r[OCTAVES-1][0];
      out_hash_r  <= chs_r[OCTAVES-1];
    end
  end

  assign out_noise_value = out_noise_r;
  assign out_cell_hash   = out_hash_r;

  // ---------------- checks ----------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted request missing from first stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v_r))
    else $error("pipeline moved while stalled");

  a_rough_sat: assert property (@(posedge clk) disable iff (!rst_n)
    rough_r <= ROUGH_ONE)
    else $error("roughness above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r[LAT-1] && out_stall))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
